// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/sqcg_pkg.sv =====
package sqcg_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 256;

  localparam int COORD_W    = 24;
  localparam int SIZE_W     = 24;
  localparam int SCALE_W    = 16;
  localparam int ANGLE_W    = 16;
  localparam int PHASE_W    = 14;
  localparam int IDX_W      = 2;
  localparam int TRIG_W     = 17;
  localparam int ENTRY_W    = 16;
  localparam int FRAC_SHIFT = 23;
  localparam int SUM_W      = 60;
  localparam int CORNERS    = 4;

  localparam int QUARTER_TURN = 16384;
  localparam int ONE_Q15      = 32768;
  localparam int ENTRY_MAX    = 32767;

  localparam logic [IDX_W-1:0] LAST_CORNER = 2'd3;

  localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef struct packed {
    logic [CORNERS-1:0][COORD_W-1:0] x;
    logic [CORNERS-1:0][COORD_W-1:0] y;
  } corner_set_t;

  // Quarter-wave sine entry in Q1.15 from an angle in Q2.30 radians.
  function automatic logic [ENTRY_W-1:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 0; n < 8; n++) begin
      term = (term * x2) >> 30;
      term = term / TAYLOR_DIV[n];
      if (!n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 64'd16384) >> 15;
    if (r > 64'(ENTRY_MAX)) begin
      r = 64'(ENTRY_MAX);
    end
    return r[ENTRY_W-1:0];
  endfunction

endpackage

// ===== rtl/sqcg_front.sv =====
module sqcg_front #(
  parameter int SINE_TABLE_DEPTH = sqcg_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [sqcg_pkg::COORD_W-1:0]    in_pos_x,
  input  logic signed [sqcg_pkg::COORD_W-1:0]    in_pos_y,
  input  logic        [sqcg_pkg::SIZE_W-1:0]     in_size_w,
  input  logic        [sqcg_pkg::SIZE_W-1:0]     in_size_h,
  input  logic signed [sqcg_pkg::SCALE_W-1:0]    in_scale_x,
  input  logic signed [sqcg_pkg::SCALE_W-1:0]    in_scale_y,
  input  logic        [sqcg_pkg::ANGLE_W-1:0]    in_angle,
  input  logic signed [sqcg_pkg::COORD_W-1:0]    in_pivot_x,
  input  logic signed [sqcg_pkg::COORD_W-1:0]    in_pivot_y,
  output logic                                   push,
  output sqcg_pkg::corner_set_t                  push_data,
  input  logic                                   q_full
);

  localparam int TIDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int TAB_AW = $clog2(SINE_TABLE_DEPTH);
  localparam int PROD_W = sqcg_pkg::PHASE_W + TIDX_W;
  localparam int CW     = sqcg_pkg::COORD_W;
  localparam int SW     = sqcg_pkg::SCALE_W;
  localparam int TW     = sqcg_pkg::TRIG_W;
  localparam int RW     = sqcg_pkg::SIZE_W + 1 + SW;
  localparam int PW     = CW + SW;
  localparam int SUMW   = sqcg_pkg::SUM_W;
  localparam int TRW    = SUMW - sqcg_pkg::FRAC_SHIFT;

  logic [sqcg_pkg::ENTRY_W-1:0] sin_tab [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [63:0] X = (sqcg_pkg::HALF_PI_Q30 * 64'(g)) / 64'(SINE_TABLE_DEPTH);
    assign sin_tab[g] = sqcg_pkg::sine_entry(X);
  end

  logic [sqcg_pkg::ANGLE_W-1:0] ang  [2];
  logic [PROD_W-1:0]            prod [2];
  logic [TIDX_W-1:0]            idx  [2];
  logic [TIDX_W-1:0]            k    [2];
  logic [TW-1:0]                mag  [2];
  logic signed [TW-1:0]         trig [2];

  always_comb begin
    ang[0] = in_angle;
    ang[1] = in_angle + sqcg_pkg::ANGLE_W'(sqcg_pkg::QUARTER_TURN);
    for (int i = 0; i < 2; i++) begin
      prod[i] = PROD_W'(ang[i][sqcg_pkg::PHASE_W-1:0]) * PROD_W'(SINE_TABLE_DEPTH);
      idx[i]  = prod[i][sqcg_pkg::PHASE_W +: TIDX_W];
      k[i]    = ang[i][sqcg_pkg::PHASE_W] ? TIDX_W'(SINE_TABLE_DEPTH) - idx[i] : idx[i];
      if (k[i] == TIDX_W'(SINE_TABLE_DEPTH)) begin
        mag[i] = TW'(sqcg_pkg::ONE_Q15);
      end else begin
        mag[i] = TW'(sin_tab[k[i][TAB_AW-1:0]]);
      end
      trig[i] = ang[i][sqcg_pkg::ANGLE_W-1] ? -$signed(mag[i]) : $signed(mag[i]);
    end
  end

  logic [4:0] vld_r;
  logic [5:0] rdy;

  always_comb begin
    rdy[5] = !q_full;
    for (int i = 4; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];
  assign push     = vld_r[4] && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < 5; i++) begin
        if (rdy[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  logic signed [CW-1:0]   s1_posx_r, s1_posy_r, s1_pvx_r, s1_pvy_r;
  logic        [CW-1:0]   s1_sw_r, s1_sh_r;
  logic signed [SW-1:0]   s1_scx_r, s1_scy_r;
  logic signed [TW-1:0]   s1_s_r, s1_c_r;

  logic signed [CW-1:0]   s2_posx_r, s2_posy_r;
  logic signed [TW-1:0]   s2_s_r, s2_c_r;
  logic signed [RW-1:0]   s2_rw_r, s2_rh_r;
  logic signed [PW-1:0]   s2_px_r, s2_py_r;

  logic signed [CW-1:0]     s3_posx_r, s3_posy_r;
  logic signed [TW+PW-1:0]  s3_cpx_r, s3_spy_r, s3_spx_r, s3_cpy_r;
  logic signed [TW+RW-1:0]  s3_wx_r, s3_wy_r, s3_shr_r, s3_hy_r;

  logic signed [SUMW-1:0] s4_ox_r, s4_oy_r, s4_wx_r, s4_wy_r, s4_hx_r, s4_hy_r;

  logic signed [SUMW-1:0] s5_x_r [sqcg_pkg::CORNERS];
  logic signed [SUMW-1:0] s5_y_r [sqcg_pkg::CORNERS];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_posx_r <= in_pos_x;
      s1_posy_r <= in_pos_y;
      s1_pvx_r  <= in_pivot_x;
      s1_pvy_r  <= in_pivot_y;
      s1_sw_r   <= in_size_w;
      s1_sh_r   <= in_size_h;
      s1_scx_r  <= in_scale_x;
      s1_scy_r  <= in_scale_y;
      s1_s_r    <= trig[0];
      s1_c_r    <= trig[1];
    end
    if (rdy[1]) begin
      s2_posx_r <= s1_posx_r;
      s2_posy_r <= s1_posy_r;
      s2_s_r    <= s1_s_r;
      s2_c_r    <= s1_c_r;
      s2_rw_r   <= $signed({1'b0, s1_sw_r}) * s1_scx_r;
      s2_rh_r   <= $signed({1'b0, s1_sh_r}) * s1_scy_r;
      s2_px_r   <= s1_pvx_r * s1_scx_r;
      s2_py_r   <= s1_pvy_r * s1_scy_r;
    end
    if (rdy[2]) begin
      s3_posx_r <= s2_posx_r;
      s3_posy_r <= s2_posy_r;
      s3_cpx_r  <= s2_c_r * s2_px_r;
      s3_spy_r  <= s2_s_r * s2_py_r;
      s3_spx_r  <= s2_s_r * s2_px_r;
      s3_cpy_r  <= s2_c_r * s2_py_r;
      s3_wx_r   <= s2_c_r * s2_rw_r;
      s3_wy_r   <= s2_s_r * s2_rw_r;
      s3_shr_r  <= s2_s_r * s2_rh_r;
      s3_hy_r   <= s2_c_r * s2_rh_r;
    end
    // The rounding half is folded into the position term, whose low bits are zero.
    if (rdy[3]) begin
      s4_ox_r <= $signed({s3_posx_r, 1'b1, 22'd0}) - s3_cpx_r + s3_spy_r;
      s4_oy_r <= $signed({s3_posy_r, 1'b1, 22'd0}) - s3_spx_r - s3_cpy_r;
      s4_wx_r <= s3_wx_r;
      s4_wy_r <= s3_wy_r;
      s4_hx_r <= -s3_shr_r;
      s4_hy_r <= s3_hy_r;
    end
    if (rdy[4]) begin
      s5_x_r[0] <= s4_ox_r;
      s5_x_r[1] <= s4_ox_r + s4_wx_r;
      s5_x_r[2] <= s4_ox_r + s4_wx_r + s4_hx_r;
      s5_x_r[3] <= s4_ox_r + s4_hx_r;
      s5_y_r[0] <= s4_oy_r;
      s5_y_r[1] <= s4_oy_r + s4_wy_r;
      s5_y_r[2] <= s4_oy_r + s4_wy_r + s4_hy_r;
      s5_y_r[3] <= s4_oy_r + s4_hy_r;
    end
  end

  function automatic logic [CW-1:0] round_sat(input logic [SUMW-1:0] v);
    logic [TRW-1:0] t;
    t = v[SUMW-1:sqcg_pkg::FRAC_SHIFT];
    if (t[TRW-1:CW-1] == '0 || t[TRW-1:CW-1] == '1) begin
      return t[CW-1:0];
    end else if (t[TRW-1]) begin
      return sqcg_pkg::COORD_MIN;
    end else begin
      return sqcg_pkg::COORD_MAX;
    end
  endfunction

  always_comb begin
    for (int i = 0; i < sqcg_pkg::CORNERS; i++) begin
      push_data.x[i] = round_sat(s5_x_r[i]);
      push_data.y[i] = round_sat(s5_y_r[i]);
    end
  end

endmodule

// ===== rtl/sqcg_queue.sv =====
module sqcg_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sqcg_pkg::corner_set_t push_data,
  output logic                  full,
  input  logic                  pop,
  output sqcg_pkg::corner_set_t head,
  output logic                  empty
);

  sqcg_pkg::corner_set_t mem_r [sqcg_pkg::QUEUE_DEPTH];

  logic [sqcg_pkg::QPTR_W-1:0] wptr_r, rptr_r;
  logic [sqcg_pkg::QCNT_W-1:0] cnt_r;

  assign full  = cnt_r == sqcg_pkg::QCNT_W'(sqcg_pkg::QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rptr_r];

  function automatic logic [sqcg_pkg::QPTR_W-1:0] bump(input logic [sqcg_pkg::QPTR_W-1:0] p);
    if (p == sqcg_pkg::QPTR_W'(sqcg_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end else begin
      return p + 1'b1;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= bump(wptr_r);
      if (pop)  rptr_r <= bump(rptr_r);
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

endmodule

// ===== rtl/sqcg_back.sv =====
module sqcg_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sqcg_pkg::corner_set_t               head,
  input  logic                                empty,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sqcg_pkg::IDX_W-1:0]          out_corner_index,
  output logic signed [sqcg_pkg::COORD_W-1:0] out_corner_x,
  output logic signed [sqcg_pkg::COORD_W-1:0] out_corner_y,
  output logic                                out_last_corner
);

  logic [sqcg_pkg::IDX_W-1:0]   cnt_r;
  logic                         out_valid_r;
  logic [sqcg_pkg::IDX_W-1:0]   idx_r;
  logic [sqcg_pkg::COORD_W-1:0] x_r, y_r;
  logic                         last_r;
  logic                         load;

  assign load = !empty && (!out_valid_r || !out_stall);
  assign pop  = load && (cnt_r == sqcg_pkg::LAST_CORNER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        cnt_r       <= cnt_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx_r  <= cnt_r;
      x_r    <= head.x[cnt_r];
      y_r    <= head.y[cnt_r];
      last_r <= cnt_r == sqcg_pkg::LAST_CORNER;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_corner_index = idx_r;
  assign out_corner_x     = $signed(x_r);
  assign out_corner_y     = $signed(y_r);
  assign out_last_corner  = last_r;

endmodule

// ===== rtl/sprite_quad_corner_generator_top.sv =====
// Sprite quad corner generator.
// The input channel (in_valid, in_stall, in_*) takes one sprite word: position,
// size, per-axis scale, binary angle and pivot. For each sprite the output
// channel (out_valid, out_stall, out_*) gives four corner words in the order
// origin, width, far and height, the fourth with out_last_corner set.
// A five-stage front pipeline looks up sine and cosine, forms the scaled
// sizes and pivot, the rotated products and the corner sums, then rounds and
// saturates them into a two-entry queue of corner sets. The back end sends one
// corner per cycle from the queue head through an output register while the
// receiver does not stall. The first corner of a sprite passes through the
// front stages, the queue and the output register. Sustained throughput is set
// by the single corner per cycle of the output register, four corners per
// sprite; the front accepts words back to back until the pipeline and queue
// are full. When the receiver stalls, the output word holds and the front
// keeps working until the queue and its pipeline fill, then stalls its input.
// Reset empties the pipeline, the queue and the output register.
module sprite_quad_corner_generator_top #(
  parameter int SINE_TABLE_DEPTH = sqcg_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sqcg_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [sqcg_pkg::COORD_W-1:0] in_pos_y,
  input  logic        [sqcg_pkg::SIZE_W-1:0]  in_size_w,
  input  logic        [sqcg_pkg::SIZE_W-1:0]  in_size_h,
  input  logic signed [sqcg_pkg::SCALE_W-1:0] in_scale_x,
  input  logic signed [sqcg_pkg::SCALE_W-1:0] in_scale_y,
  input  logic        [sqcg_pkg::ANGLE_W-1:0] in_angle,
  input  logic signed [sqcg_pkg::COORD_W-1:0] in_pivot_x,
  input  logic signed [sqcg_pkg::COORD_W-1:0] in_pivot_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sqcg_pkg::IDX_W-1:0]          out_corner_index,
  output logic signed [sqcg_pkg::COORD_W-1:0] out_corner_x,
  output logic signed [sqcg_pkg::COORD_W-1:0] out_corner_y,
  output logic                                out_last_corner
);

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_empty;
  sqcg_pkg::corner_set_t q_push_data;
  sqcg_pkg::corner_set_t q_head;

  sqcg_front #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .in_size_w (in_size_w),
    .in_size_h (in_size_h),
    .in_scale_x(in_scale_x),
    .in_scale_y(in_scale_y),
    .in_angle  (in_angle),
    .in_pivot_x(in_pivot_x),
    .in_pivot_y(in_pivot_y),
    .push      (q_push),
    .push_data (q_push_data),
    .q_full    (q_full)
  );

  sqcg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  sqcg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .empty           (q_empty),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_corner_index(out_corner_index),
    .out_corner_x    (out_corner_x),
    .out_corner_y    (out_corner_y),
    .out_last_corner (out_last_corner)
  );

`include "assert_macros.svh"

  `ASSERT_IMPL(a_no_overflow, clk, rst_n, q_push, !q_full || q_pop)
  `ASSERT_IMPL(a_last_flag, clk, rst_n, out_valid, out_last_corner == (out_corner_index == sqcg_pkg::LAST_CORNER))
  `ASSERT_NEXT(a_corner_seq, clk, rst_n, out_valid && !out_stall && out_corner_index != sqcg_pkg::LAST_CORNER, out_valid && out_corner_index == $past(out_corner_index) + 2'd1)
  `ASSERT_IMPL(a_pop_needs_entry, clk, rst_n, q_pop, !q_empty)

endmodule
